[rtl/core/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform package
// Opcodes, fixed-point coefficients and the reciprocal constants used by the
// sine/cosine series in the transform pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

  typedef enum logic [1:0] {
    OP_CLARKE     = 2'd0,
    OP_PARK       = 2'd1,
    OP_INV_PARK   = 2'd2,
    OP_INV_CLARKE = 2'd3
  } opcode_e;

  // Unity in Q30, as the 31-bit magnitude used by the series.
  localparam logic [30:0] P_ONE = 31'h4000_0000;

  // Transform coefficients in Q30.
  localparam logic signed [31:0] K_S23  = 32'sd876706528;   // sqrt(2/3)
  localparam logic signed [31:0] K_S23H = 32'sd438353264;   // sqrt(2/3)/2
  localparam logic signed [31:0] K_R2H  = 32'sd759250125;   // sqrt(2)/2
  localparam logic [30:0]        K_HPI  = 31'd1686629713;   // pi/2

  // Series divisors. Each division of a 32-bit value by d is done as a
  // multiplication by ceil(2^s / d) followed by a shift by s, which is exact
  // for all 32-bit dividends when s = 32 + ceil(log2(d)).
  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;

  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  localparam int SIN_SH [SIN_STEPS] = '{39, 39, 38, 37, 35};
  localparam int COS_SH [COS_STEPS] = '{40, 39, 38, 37, 36, 33};

  localparam logic [32:0] SIN_MUL [SIN_STEPS] = '{
    33'(((64'd1 << SIN_SH[0]) + 64'(SIN_DIV[0]) - 64'd1) / 64'(SIN_DIV[0])),
    33'(((64'd1 << SIN_SH[1]) + 64'(SIN_DIV[1]) - 64'd1) / 64'(SIN_DIV[1])),
    33'(((64'd1 << SIN_SH[2]) + 64'(SIN_DIV[2]) - 64'd1) / 64'(SIN_DIV[2])),
    33'(((64'd1 << SIN_SH[3]) + 64'(SIN_DIV[3]) - 64'd1) / 64'(SIN_DIV[3])),
    33'(((64'd1 << SIN_SH[4]) + 64'(SIN_DIV[4]) - 64'd1) / 64'(SIN_DIV[4]))
  };

  localparam logic [32:0] COS_MUL [COS_STEPS] = '{
    33'(((64'd1 << COS_SH[0]) + 64'(COS_DIV[0]) - 64'd1) / 64'(COS_DIV[0])),
    33'(((64'd1 << COS_SH[1]) + 64'(COS_DIV[1]) - 64'd1) / 64'(COS_DIV[1])),
    33'(((64'd1 << COS_SH[2]) + 64'(COS_DIV[2]) - 64'd1) / 64'(COS_DIV[2])),
    33'(((64'd1 << COS_SH[3]) + 64'(COS_DIV[3]) - 64'd1) / 64'(COS_DIV[3])),
    33'(((64'd1 << COS_SH[4]) + 64'(COS_DIV[4]) - 64'd1) / 64'(COS_DIV[4])),
    33'(((64'd1 << COS_SH[5]) + 64'(COS_DIV[5]) - 64'd1) / 64'(COS_DIV[5]))
  };

endpackage

[rtl/core/cpt_in_if.sv]
// ----------------------------------------------------------------------------
// Transform request channel
// Valid/ready channel carrying one transform request per item.
// ----------------------------------------------------------------------------
interface cpt_in_if #(
  parameter int DATA_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [DATA_WIDTH-1:0]  in_x;
  logic signed [DATA_WIDTH-1:0]  in_y;
  logic signed [DATA_WIDTH-1:0]  in_z;
  logic [ANGLE_WIDTH-1:0]        angle;

  modport source (
    output valid, opcode, in_x, in_y, in_z, angle,
    input  ready
  );

  modport sink (
    input  valid, opcode, in_x, in_y, in_z, angle,
    output ready
  );
endinterface

[rtl/core/cpt_out_if.sv]
// ----------------------------------------------------------------------------
// Transform result channel
// Valid/ready channel carrying one transform result per item.
// ----------------------------------------------------------------------------
interface cpt_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  out_x;
  logic signed [DATA_WIDTH-1:0]  out_y;
  logic signed [DATA_WIDTH-1:0]  out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );
endinterface

[rtl/core/clarke_park_transform.sv]
// ----------------------------------------------------------------------------
// Clarke/Park coordinate transform
// Power-invariant Clarke, Park and their inverses on Q3.13 data.
// ----------------------------------------------------------------------------
// Requests enter on in_i: an opcode, three signed operands and an angle where
// 2^ANGLE_WIDTH is one full turn. Results leave on out_o, one per request, in
// request order. Both channels move an item when valid and ready are high.
//
// The block is an 18-stage pipeline followed by an output register and a
// skid register. One item is accepted every cycle while the skid register
// is empty. The pipeline depth is set by the sine and cosine series: six
// cosine and five sine multiply/reciprocal steps of two stages each, run
// as two parallel lanes.
//
// Reset clears all valid bits, those of the output and skid registers too.
// When the receiver stalls, the next result is parked in the skid register
// and the pipeline keeps moving for that cycle; once the skid register is
// occupied, in_i.ready drops and every stage holds its item until out_o.ready
// returns. No item is dropped or repeated.
// ----------------------------------------------------------------------------
module clarke_park_transform #(
  parameter int DATA_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpt_in_if.sink     in_i,
  cpt_out_if.source  out_o
);

  localparam int FB  = ANGLE_WIDTH - 2;   // angle bits inside one quadrant
  localparam int NST = 18;                 // pipeline stages
  localparam int PW  = DATA_WIDTH + 32;    // product width
  localparam int AW  = PW + 2;             // accumulator width
  localparam int RW  = AW - 30;            // width after the Q30 shift

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [RW-1:0] rnd_t;

  typedef struct packed {
    cpt_pkg::opcode_e             op;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] z;
    logic [1:0]                   quad;
  } side_t;

  localparam logic [FB+31:0] XRND = {32'd0, 1'b1, {(FB-1){1'b0}}};
  localparam logic [61:0]    X2RND = {32'd0, 1'b1, 29'd0};
  localparam acc_t RND_HALF = {{(AW-30){1'b0}}, 1'b1, 29'd0};
  localparam rnd_t SAT_MAX = {{(RW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam rnd_t SAT_MIN = {{(RW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  // Control
  logic [NST:1] v_q;
  logic         en;
  logic         out_v_q;
  logic         skid_v_q;
  logic         load;
  logic         out_free;

  // Payload
  side_t        side_q [1:NST];
  logic [FB-1:0] t_q;
  logic [30:0]  x_q  [2:13];
  logic [31:0]  x2_q [3:13];
  logic [31:0]  cn_q [cpt_pkg::COS_STEPS];
  logic [31:0]  cq_q [cpt_pkg::COS_STEPS];
  logic [31:0]  sn_q [cpt_pkg::SIN_STEPS];
  logic [31:0]  sq_q [cpt_pkg::SIN_STEPS];
  logic [30:0]  sv_q [14:15];
  logic signed [31:0] co_q [8];
  prod_t        pr_q [8];
  acc_t         acc_q [3];

  logic signed [DATA_WIDTH-1:0] res   [3];
  logic signed [DATA_WIDTH-1:0] out_q [3];
  logic signed [DATA_WIDTH-1:0] skid_q [3];

  // The pipeline moves as a whole; only a full skid register stops it.
  assign en         = !skid_v_q;
  assign in_i.ready = en;
  assign load       = en && v_q[NST];
  assign out_free   = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-1:1], in_i.valid};
    end
  end

  // Stage 1: capture the item.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1].op   <= cpt_pkg::opcode_e'(in_i.opcode);
      side_q[1].x    <= in_i.in_x;
      side_q[1].y    <= in_i.in_y;
      side_q[1].z    <= in_i.in_z;
      side_q[1].quad <= in_i.angle[ANGLE_WIDTH-1 -: 2];
      t_q            <= in_i.angle[FB-1:0];
    end
  end

  for (genvar k = 2; k <= NST; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 2: angle inside the quadrant to radians in Q30.
  logic [FB+30:0] xmul;
  logic [FB+31:0] xsum;
  assign xmul = t_q * cpt_pkg::K_HPI;
  assign xsum = {1'b0, xmul} + XRND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[2] <= xsum[FB+30:FB];
    end
  end

  // Stage 3: x squared, rounded to Q30.
  logic [61:0] x2mul;
  logic [61:0] x2sum;
  assign x2mul = x_q[2] * x_q[2];
  assign x2sum = x2mul + X2RND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q[3] <= x2sum[61:30];
      x_q[3]  <= x_q[2];
    end
  end

  for (genvar k = 4; k <= 13; k++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[k]  <= x_q[k-1];
        x2_q[k] <= x2_q[k-1];
      end
    end
  end

  // Series steps: p = 1 - floor(x2 * p) / d. Step k multiplies at stage 4+2k
  // and applies the reciprocal at stage 5+2k. Intermediate p stays in [0, 1].
  for (genvar k = 0; k < cpt_pkg::COS_STEPS; k++) begin : g_cos
    logic [30:0] p;
    logic [62:0] nmul;
    logic [64:0] qmul;

    if (k == 0) begin : g_first
      assign p = cpt_pkg::P_ONE;
    end else begin : g_next
      assign p = cpt_pkg::P_ONE - cq_q[k-1][30:0];
    end

    assign nmul = x2_q[3+2*k] * p;
    assign qmul = cn_q[k] * cpt_pkg::COS_MUL[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        cn_q[k] <= nmul[61:30];
        cq_q[k] <= 32'(qmul >> cpt_pkg::COS_SH[k]);
      end
    end
  end

  for (genvar k = 0; k < cpt_pkg::SIN_STEPS; k++) begin : g_sin
    logic [30:0] p;
    logic [62:0] nmul;
    logic [64:0] qmul;

    if (k == 0) begin : g_first
      assign p = cpt_pkg::P_ONE;
    end else begin : g_next
      assign p = cpt_pkg::P_ONE - sq_q[k-1][30:0];
    end

    assign nmul = x2_q[3+2*k] * p;
    assign qmul = sn_q[k] * cpt_pkg::SIN_MUL[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_q[k] <= nmul[61:30];
        sq_q[k] <= 32'(qmul >> cpt_pkg::SIN_SH[k]);
      end
    end
  end

  // Stage 14: sine = x * p, clamped to one. Stage 15 waits for the cosine.
  logic [30:0] sp;
  logic [61:0] smul;
  logic [31:0] sval;
  assign sp   = cpt_pkg::P_ONE - sq_q[cpt_pkg::SIN_STEPS-1][30:0];
  assign smul = x_q[13] * sp;
  assign sval = smul[61:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sv_q[14] <= (sval > {1'b0, cpt_pkg::P_ONE}) ? cpt_pkg::P_ONE : sval[30:0];
      sv_q[15] <= sv_q[14];
    end
  end

  // Stage 16: finish the cosine, mirror by quadrant and pick coefficients.
  // Coefficient order: x, y, z for the first result, the same for the
  // second, then x and y for the third.
  logic signed [32:0] cdiff;
  logic [30:0]        cv;
  logic signed [31:0] sv32;
  logic signed [31:0] cv32;
  logic signed [31:0] s_w;
  logic signed [31:0] c_w;
  logic signed [31:0] co_d [8];

  assign cdiff = $signed({2'b00, cpt_pkg::P_ONE}) -
                 $signed({1'b0, cq_q[cpt_pkg::COS_STEPS-1]});
  assign cv    = cdiff[32] ? 31'd0 : cdiff[30:0];
  assign sv32  = $signed({1'b0, sv_q[15]});
  assign cv32  = $signed({1'b0, cv});

  always_comb begin
    case (side_q[15].quad)
      2'd0: begin
        s_w = sv32;
        c_w = cv32;
      end
      2'd1: begin
        s_w = cv32;
        c_w = -sv32;
      end
      2'd2: begin
        s_w = -sv32;
        c_w = -cv32;
      end
      default: begin
        s_w = -cv32;
        c_w = sv32;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      co_d[i] = '0;
    end
    case (side_q[15].op)
      cpt_pkg::OP_CLARKE: begin
        co_d[0] = cpt_pkg::K_S23;
        co_d[1] = -cpt_pkg::K_S23H;
        co_d[2] = -cpt_pkg::K_S23H;
        co_d[4] = cpt_pkg::K_R2H;
        co_d[5] = -cpt_pkg::K_R2H;
      end
      cpt_pkg::OP_PARK: begin
        co_d[0] = c_w;
        co_d[1] = s_w;
        co_d[3] = -s_w;
        co_d[4] = c_w;
      end
      cpt_pkg::OP_INV_PARK: begin
        co_d[0] = c_w;
        co_d[1] = -s_w;
        co_d[3] = s_w;
        co_d[4] = c_w;
      end
      default: begin
        co_d[0] = cpt_pkg::K_S23;
        co_d[3] = -cpt_pkg::K_S23H;
        co_d[4] = cpt_pkg::K_R2H;
        co_d[6] = -cpt_pkg::K_S23H;
        co_d[7] = -cpt_pkg::K_R2H;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q <= co_d;
    end
  end

  // Stage 17: products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0] <= prod_t'(co_q[0]) * prod_t'(side_q[16].x);
      pr_q[1] <= prod_t'(co_q[1]) * prod_t'(side_q[16].y);
      pr_q[2] <= prod_t'(co_q[2]) * prod_t'(side_q[16].z);
      pr_q[3] <= prod_t'(co_q[3]) * prod_t'(side_q[16].x);
      pr_q[4] <= prod_t'(co_q[4]) * prod_t'(side_q[16].y);
      pr_q[5] <= prod_t'(co_q[5]) * prod_t'(side_q[16].z);
      pr_q[6] <= prod_t'(co_q[6]) * prod_t'(side_q[16].x);
      pr_q[7] <= prod_t'(co_q[7]) * prod_t'(side_q[16].y);
    end
  end

  // Stage 18: sums with the rounding half added.
  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q[0] <= acc_t'(pr_q[0]) + acc_t'(pr_q[1]) + acc_t'(pr_q[2]) + RND_HALF;
      acc_q[1] <= acc_t'(pr_q[3]) + acc_t'(pr_q[4]) + acc_t'(pr_q[5]) + RND_HALF;
      acc_q[2] <= acc_t'(pr_q[6]) + acc_t'(pr_q[7]) + RND_HALF;
    end
  end

  // Drop the Q30 fraction (floor) and saturate to the data range.
  for (genvar j = 0; j < 3; j++) begin : g_sat
    rnd_t r;
    assign r = $signed(acc_q[j][AW-1:30]);
    assign res[j] = (r > SAT_MAX) ? SAT_MAX[DATA_WIDTH-1:0] :
                    (r < SAT_MIN) ? SAT_MIN[DATA_WIDTH-1:0] :
                                    r[DATA_WIDTH-1:0];
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= load;
      end
    end else if (load) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (load) begin
        out_q <= res;
      end
    end else if (load) begin
      skid_q <= res;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.out_x = out_q[0];
  assign out_o.out_y = out_q[1];
  assign out_o.out_z = out_q[2];

endmodule
